[rtl/core/edfd_pkg.sv]
// shared types and constants for the edf periodic task dispatcher
`default_nettype none

package edfd_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int TIME_BITS  = 32;
	localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
	localparam int CNT_BITS   = $clog2(TASK_SLOTS + 1);
	localparam int REL_BITS   = TIME_BITS + 1;
	localparam int FIELD_BITS = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS  = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [SLOT_BITS-1:0]  slot;
		logic [FIELD_BITS-1:0] exec;
		logic [FIELD_BITS-1:0] period;
		logic [FIELD_BITS-1:0] arrival;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

`default_nettype wire

[rtl/core/edf_periodic_task_dispatcher.sv]
// edf periodic task dispatcher top level: config register, front queue, scan engine
// load beat: leaves the queue in the same cycle as it writes its slot
// tick beat: scans up to 16 active slots, drains, then finishes; with none, straight to finish
// a two entry input queue lets new beats arrive while a tick is scanned
// the result register holds a finished beat while the next item is taken
// reset clears time, remaining work, slot count, queue and result valid; slot tables stay unset
`default_nettype none

module edf_periodic_task_dispatcher
	import edfd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CNT_BITS-1:0]   cfg_wr_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  action,
	input  wire logic [SLOT_BITS-1:0]  slot_index,
	input  wire logic [FIELD_BITS-1:0] exec_time,
	input  wire logic [FIELD_BITS-1:0] task_period,
	input  wire logic [FIELD_BITS-1:0] first_arrival,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [CNT_BITS-1:0]        running_task,
	output logic [TIME_BITS-1:0]       tick_time,
	output logic [REL_BITS-1:0]        chosen_deadline
);

	logic [CNT_BITS-1:0] active_count_q;
	queue_head_t         head;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= '0;
		end else if (cfg_wr_en) begin
			active_count_q <= cfg_wr_data;
		end
	end

	edfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.slot_index    (slot_index),
		.exec_time     (exec_time),
		.task_period   (task_period),
		.first_arrival (first_arrival),
		.head          (head),
		.pop           (pop)
	);

	edfd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.active_count    (active_count_q),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.running_task    (running_task),
		.tick_time       (tick_time),
		.chosen_deadline (chosen_deadline)
	);

endmodule

`default_nettype wire

[rtl/core/edfd_front.sv]
// front end: accepts input beats, decodes the action and queues them
`default_nettype none

module edfd_front
	import edfd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  action,
	input  wire logic [SLOT_BITS-1:0]  slot_index,
	input  wire logic [FIELD_BITS-1:0] exec_time,
	input  wire logic [FIELD_BITS-1:0] task_period,
	input  wire logic [FIELD_BITS-1:0] first_arrival,
	output queue_head_t                head,
	input  wire logic                  pop
);

	item_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 push;
	logic                 do_pop;
	item_t                decoded;

	always_comb begin
		decoded.op      = action ? OP_TICK : OP_LOAD;
		decoded.slot    = slot_index;
		decoded.exec    = exec_time;
		decoded.period  = task_period;
		decoded.arrival = first_arrival;
	end

	assign in_stall   = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/edfd_back.sv]
// back end: slot table, release and earliest deadline scan, result register
`default_nettype none

module edfd_back
	import edfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [CNT_BITS-1:0]  active_count,
	input  wire queue_head_t          head,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CNT_BITS-1:0]       running_task,
	output logic [TIME_BITS-1:0]      tick_time,
	output logic [REL_BITS-1:0]       chosen_deadline
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                state_q;
	logic [FIELD_BITS-1:0] work_q   [TASK_SLOTS];
	logic [FIELD_BITS-1:0] exec_q   [TASK_SLOTS];
	logic [FIELD_BITS-1:0] period_q [TASK_SLOTS];
	logic [REL_BITS-1:0]   rel_q    [TASK_SLOTS];
	logic [TIME_BITS-1:0]  time_q;
	logic [SLOT_BITS-1:0]  idx_q;
	logic [CNT_BITS-1:0]   n_q;
	logic [CNT_BITS-1:0]   n_clamped;
	logic                  found_q;
	logic [SLOT_BITS-1:0]  best_q;
	logic [REL_BITS-1:0]   best_dl_q;
	logic                  valid_s1;
	logic                  pend_s1;
	logic [SLOT_BITS-1:0]  idx_s1;
	logic [REL_BITS-1:0]   rel_s1;
	logic                  out_valid_q;
	logic [CNT_BITS-1:0]   running_q;
	logic [TIME_BITS-1:0]  tick_time_q;
	logic [REL_BITS-1:0]   deadline_q;

	logic                  rd_release;
	logic [REL_BITS-1:0]   rd_rel_new;
	logic [FIELD_BITS-1:0] rd_work_new;
	logic                  scan_last;
	logic                  out_free;
	logic                  do_load;
	logic                  do_finish;

	assign n_clamped = (active_count > CNT_BITS'(TASK_SLOTS)) ?
		CNT_BITS'(TASK_SLOTS) : active_count;

	// release check on the slot under the scan pointer
	assign rd_release  = (rel_q[idx_q] == {1'b0, time_q});
	assign rd_rel_new  = rd_release ?
		(rel_q[idx_q] + REL_BITS'(period_q[idx_q])) : rel_q[idx_q];
	assign rd_work_new = rd_release ? exec_q[idx_q] : work_q[idx_q];
	assign scan_last   = ({1'b0, idx_q} == (n_q - 1'b1));

	assign out_free  = !out_valid_q || !out_stall;
	assign do_load   = (state_q == ST_IDLE) && head.valid && (head.item.op == OP_LOAD);
	assign do_finish = (state_q == ST_FINISH) && out_free;
	assign pop       = (state_q == ST_IDLE) && head.valid;

	assign out_valid       = out_valid_q;
	assign running_task    = running_q;
	assign tick_time       = tick_time_q;
	assign chosen_deadline = deadline_q;

	// slot tables without reset
	always_ff @(posedge clk) begin
		if (do_load) begin
			exec_q[head.item.slot]   <= head.item.exec;
			period_q[head.item.slot] <= head.item.period;
			rel_q[head.item.slot]    <= REL_BITS'(head.item.arrival);
		end else if (state_q == ST_SCAN) begin
			rel_q[idx_q] <= rd_rel_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				work_q[i] <= '0;
			end
		end else begin
			if (do_load) begin
				work_q[head.item.slot] <= '0;
			end else if (state_q == ST_SCAN) begin
				work_q[idx_q] <= rd_work_new;
			end else if (do_finish && found_q) begin
				work_q[best_q] <= work_q[best_q] - 1'b1;
			end
		end
	end

	// scan pipeline stage
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		rel_s1  <= rd_rel_new;
		pend_s1 <= (rd_work_new != '0);
	end

	always_ff @(posedge clk) begin
		if (do_finish) begin
			running_q   <= found_q ? (CNT_BITS'(best_q) + 1'b1) : '0;
			tick_time_q <= time_q;
			deadline_q  <= found_q ? best_dl_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_dl_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SCAN);
			if (out_free) begin
				out_valid_q <= do_finish;
			end
			if (valid_s1 && pend_s1 && (!found_q || (rel_s1 < best_dl_q))) begin
				found_q   <= 1'b1;
				best_q    <= idx_s1;
				best_dl_q <= rel_s1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid && (head.item.op == OP_TICK)) begin
						idx_q   <= '0;
						n_q     <= n_clamped;
						found_q <= 1'b0;
						state_q <= (n_clamped == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						if (time_q != '1) begin
							time_q <= time_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
